// ----- hw/rtl/cvq_pkg.sv -----
// shared types, constants and helpers for the qe variance step
// no dependencies; used by every module of the block
`default_nettype none
package cvq_pkg;

  localparam int unsigned FRAC_BITS_DEF = 24;

  localparam logic [63:0] ONE_Q   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  localparam logic [31:0] MEAN_RST  = 32'd671089;
  localparam logic [31:0] DECAY_RST = 32'd4252017623;
  localparam logic [31:0] VOL_RST   = 32'd8388608;
  localparam logic [31:0] SPEED_RST = 32'd16777216;
  localparam logic [31:0] PSI_RST   = 32'd25165824;

  localparam logic [1:0] BR_QUAD = 2'd0;
  localparam logic [1:0] BR_ZERO = 2'd1;
  localparam logic [1:0] BR_TAIL = 2'd2;

  typedef enum logic [2:0] {
    REG_MEAN  = 3'd0,
    REG_DECAY = 3'd1,
    REG_VOL   = 3'd2,
    REG_SPEED = 3'd3,
    REG_PSI   = 3'd4
  } reg_idx_t;

  // everything an item drags along the pipeline
  typedef struct packed {
    logic [23:0] z;
    logic [31:0] u;
    logic        ge;
    logic [63:0] vw;
    logic [63:0] m;
    logic [63:0] m2;
    logic [63:0] psi;
    logic [63:0] q;
    logic [63:0] p;
    logic [63:0] b2;
    logic [63:0] a;
    logic [63:0] ratio;
    logic [63:0] qres;
    logic [4:0]  n;
    logic [31:0] frac;
  } ctx_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // log2 range reduction: shift so the value lies below 2^33
  function automatic logic [4:0] ln_shift(input logic [63:0] x);
    logic [4:0] n;
    n = '0;
    for (int i = 33; i < 64; i++) begin
      if (x[i]) begin
        n = 5'(i - 32);
      end
    end
    return n;
  endfunction

  function automatic ctx_t push_frac(input ctx_t c, input logic b);
    ctx_t r;
    r = c;
    r.frac = {c.frac[30:0], b};
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cir_variance_qe_step.sv -----
// throughput: one beat per cycle while the skid stage is empty, set by the
// fully pipelined dividers (one quotient bit per stage), square roots and the 32
// squarings of the logarithm
// reset: synchronous active-low; clears all valid bits and loads the registers
// with their documented defaults; no clearing pass, the block is ready at once
`default_nettype none
module cir_variance_qe_step #(
  parameter int unsigned FRAC_BITS = cvq_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input beat: current_variance [31:0], normal_sample [55:32], uniform_sample [87:56]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,
  // result beat: next_variance [31:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,
  // branch_used [1:0]
  output logic [1:0]       out_tuser,
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int SH = 32 - FRAC_BITS;
  localparam logic [63:0] ONE = cvq_pkg::ONE_Q;

  // settings registers
  logic [31:0] mean_r, decay_r, vol_r, speed_r, psi_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r  <= cvq_pkg::MEAN_RST;
      decay_r <= cvq_pkg::DECAY_RST;
      vol_r   <= cvq_pkg::VOL_RST;
      speed_r <= cvq_pkg::SPEED_RST;
      psi_r   <= cvq_pkg::PSI_RST;
    end else if (cfg_valid) begin
      unique case (cvq_pkg::reg_idx_t'(cfg_index))
        cvq_pkg::REG_MEAN:  mean_r  <= cfg_data;
        cvq_pkg::REG_DECAY: decay_r <= cfg_data;
        cvq_pkg::REG_VOL:   vol_r   <= cfg_data;
        cvq_pkg::REG_SPEED: speed_r <= cfg_data;
        cvq_pkg::REG_PSI:   psi_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // settings widened to Q32.32
  logic [63:0] thw, sgw, kpw, pcw, ew, omew;
  assign thw  = 64'(mean_r)  << SH;
  assign sgw  = 64'(vol_r)   << SH;
  assign kpw  = 64'(speed_r) << SH;
  assign pcw  = 64'(psi_r)   << SH;
  assign ew   = 64'(decay_r);
  assign omew = ONE - 64'(decay_r);

  // whole pipeline moves together; only a full skid stage holds it
  logic adv;
  logic skid_valid_r;
  assign adv       = !skid_valid_r;
  assign in_tready = adv;

  // ---- link 1: |v - theta| * E and sigma^2
  cvq_pkg::ctx_t c1, c1o;
  logic [63:0]   d1, p1a, p1b;
  logic          v1;

  always_comb begin
    c1    = '0;
    c1.vw = 64'(in_tdata[31:0]) << SH;
    c1.z  = in_tdata[55:32];
    c1.u  = in_tdata[87:56];
    c1.ge = c1.vw >= thw;
    d1    = c1.ge ? c1.vw - thw : thw - c1.vw;
  end

  cvq_mul u_m1a (.clk, .rst_n, .en(adv), .in_valid(in_tvalid), .in_a(d1), .in_b(ew),
                 .in_ctx(c1), .out_valid(v1), .out_p(p1a), .out_ctx(c1o));
  cvq_mul u_m1b (.clk, .rst_n, .en(adv), .in_valid(in_tvalid), .in_a(sgw), .in_b(sgw),
                 .in_ctx(c1), .out_valid(), .out_p(p1b), .out_ctx());

  // ---- link 2: conditional mean m, then v*sg2, theta*sg2, m*m
  cvq_pkg::ctx_t c2, c2o;
  logic [63:0]   p2a, p2b, p2c;
  logic          v2;

  always_comb begin
    c2   = c1o;
    c2.m = c1o.ge ? cvq_pkg::sat_add(thw, p1a) : thw - p1a;
  end

  cvq_mul u_m2a (.clk, .rst_n, .en(adv), .in_valid(v1), .in_a(c2.vw), .in_b(p1b),
                 .in_ctx(c2), .out_valid(v2), .out_p(p2a), .out_ctx(c2o));
  cvq_mul u_m2b (.clk, .rst_n, .en(adv), .in_valid(v1), .in_a(thw), .in_b(p1b),
                 .in_ctx(c2), .out_valid(), .out_p(p2b), .out_ctx());
  cvq_mul u_m2c (.clk, .rst_n, .en(adv), .in_valid(v1), .in_a(c2.m), .in_b(c2.m),
                 .in_ctx(c2), .out_valid(), .out_p(p2c), .out_ctx());

  // ---- links 3 and 4: scale by E*(1-E) and (1-E)^2
  cvq_pkg::ctx_t c3, c3o, c4o;
  logic [63:0]   p3a, p3b, p4a, p4b;
  logic          v3, v4;

  always_comb begin
    c3    = c2o;
    c3.m2 = p2c;
  end

  cvq_mul u_m3a (.clk, .rst_n, .en(adv), .in_valid(v2), .in_a(p2a), .in_b(ew),
                 .in_ctx(c3), .out_valid(v3), .out_p(p3a), .out_ctx(c3o));
  cvq_mul u_m3b (.clk, .rst_n, .en(adv), .in_valid(v2), .in_a(p2b), .in_b(omew),
                 .in_ctx(c3), .out_valid(), .out_p(p3b), .out_ctx());
  cvq_mul u_m4a (.clk, .rst_n, .en(adv), .in_valid(v3), .in_a(p3a), .in_b(omew),
                 .in_ctx(c3o), .out_valid(v4), .out_p(p4a), .out_ctx(c4o));
  cvq_mul u_m4b (.clk, .rst_n, .en(adv), .in_valid(v3), .in_a(p3b), .in_b(omew),
                 .in_ctx(c3o), .out_valid(), .out_p(p4b), .out_ctx());

  // ---- link 5: both variance terms divided by kappa
  cvq_pkg::ctx_t c5o;
  logic [63:0]   q5a, q5b;
  logic          v5;

  cvq_rec #(.SQRT(1'b0)) u_d5a (.clk, .rst_n, .en(adv), .in_valid(v4), .in_a(p4a),
    .in_b(kpw), .in_ctx(c4o), .out_valid(v5), .out_q(q5a), .out_ctx(c5o));
  cvq_rec #(.SQRT(1'b0)) u_d5b (.clk, .rst_n, .en(adv), .in_valid(v4), .in_a(p4b),
    .in_b(kpw), .in_ctx(c4o), .out_valid(), .out_q(q5b), .out_ctx());

  // ---- link 6: psi = s2 / m^2 (zero m^2 saturates in the divider)
  cvq_pkg::ctx_t c6o;
  logic [63:0]   s2, q6;
  logic          v6;

  assign s2 = cvq_pkg::sat_add(q5a, q5b >> 1);

  cvq_rec #(.SQRT(1'b0)) u_d6 (.clk, .rst_n, .en(adv), .in_valid(v5), .in_a(s2),
    .in_b(c5o.m2), .in_ctx(c5o), .out_valid(v6), .out_q(q6), .out_ctx(c6o));

  // ---- link 7: 2/psi and (psi-1)/(psi+1)
  cvq_pkg::ctx_t c7, c7o;
  logic [63:0]   q7a, q7b;
  logic          v7;

  always_comb begin
    c7     = c6o;
    c7.psi = q6;
  end

  cvq_rec #(.SQRT(1'b0)) u_d7a (.clk, .rst_n, .en(adv), .in_valid(v6), .in_a(ONE << 1),
    .in_b(q6), .in_ctx(c7), .out_valid(v7), .out_q(q7a), .out_ctx(c7o));
  cvq_rec #(.SQRT(1'b0)) u_d7b (.clk, .rst_n, .en(adv), .in_valid(v6), .in_a(q6 - ONE),
    .in_b(cvq_pkg::sat_add(q6, ONE)), .in_ctx(c7), .out_valid(), .out_q(q7b), .out_ctx());

  // ---- link 8: q = 2/psi - 1 clamped, p clamped below one; roots of 2/psi and q
  cvq_pkg::ctx_t c8, c8o;
  logic [63:0]   r8a, r8b;
  logic          v8;

  always_comb begin
    c8   = c7o;
    c8.q = (q7a > ONE) ? q7a - ONE : '0;
    if (c7o.psi > ONE) begin
      c8.p = (q7b >= ONE) ? ONE - 64'd1 : q7b;
    end else begin
      c8.p = '0;
    end
  end

  cvq_rec #(.SQRT(1'b1)) u_r8a (.clk, .rst_n, .en(adv), .in_valid(v7), .in_a(q7a),
    .in_b('0), .in_ctx(c8), .out_valid(v8), .out_q(r8a), .out_ctx(c8o));
  cvq_rec #(.SQRT(1'b1)) u_r8b (.clk, .rst_n, .en(adv), .in_valid(v7), .in_a(c8.q),
    .in_b('0), .in_ctx(c8), .out_valid(), .out_q(r8b), .out_ctx());

  // ---- link 9: product of the roots
  cvq_pkg::ctx_t c9o;
  logic [63:0]   p9;
  logic          v9;

  cvq_mul u_m9 (.clk, .rst_n, .en(adv), .in_valid(v8), .in_a(r8a), .in_b(r8b),
                .in_ctx(c8o), .out_valid(v9), .out_p(p9), .out_ctx(c9o));

  // ---- link 10: a = m/(1+b2) and the tail ratio (1-p)/(1-u)
  cvq_pkg::ctx_t c10, c10o;
  logic [63:0]   q10a, q10b;
  logic          v10;

  always_comb begin
    c10    = c9o;
    c10.b2 = cvq_pkg::sat_add(c9o.q, p9);
  end

  cvq_rec #(.SQRT(1'b0)) u_d10a (.clk, .rst_n, .en(adv), .in_valid(v9), .in_a(c10.m),
    .in_b(cvq_pkg::sat_add(ONE, c10.b2)), .in_ctx(c10), .out_valid(v10), .out_q(q10a),
    .out_ctx(c10o));
  cvq_rec #(.SQRT(1'b0)) u_d10b (.clk, .rst_n, .en(adv), .in_valid(v9), .in_a(ONE - c10.p),
    .in_b(ONE - 64'(c10.u)), .in_ctx(c10), .out_valid(), .out_q(q10b), .out_ctx());

  // ---- link 11: sqrt(b2)
  cvq_pkg::ctx_t c11, c11o;
  logic [63:0]   r11;
  logic          v11;

  always_comb begin
    c11       = c10o;
    c11.a     = q10a;
    c11.ratio = q10b;
  end

  cvq_rec #(.SQRT(1'b1)) u_r11 (.clk, .rst_n, .en(adv), .in_valid(v10), .in_a(c11.b2),
    .in_b('0), .in_ctx(c11), .out_valid(v11), .out_q(r11), .out_ctx(c11o));

  // ---- links 12 and 13: w = sqrt(b2)+z by magnitude, then a*w^2
  cvq_pkg::ctx_t c12o, c13o;
  logic [63:0]   zm, w, p12, p13;
  logic [23:0]   zmag;
  logic          zneg, v12, v13;

  always_comb begin
    zneg = c11o.z[23];
    zmag = zneg ? (~c11o.z + 24'd1) : c11o.z;
    zm   = 64'(zmag) << 12;
    if (!zneg) begin
      w = cvq_pkg::sat_add(r11, zm);
    end else begin
      w = (r11 >= zm) ? r11 - zm : zm - r11;
    end
  end

  cvq_mul u_m12 (.clk, .rst_n, .en(adv), .in_valid(v11), .in_a(w), .in_b(w),
                 .in_ctx(c11o), .out_valid(v12), .out_p(p12), .out_ctx(c12o));
  cvq_mul u_m13 (.clk, .rst_n, .en(adv), .in_valid(v12), .in_a(c12o.a), .in_b(p12),
                 .in_ctx(c12o), .out_valid(v13), .out_p(p13), .out_ctx(c13o));

  // ---- logarithm: range shift, then one squaring per fraction bit
  cvq_pkg::ctx_t lc  [33];
  cvq_pkg::ctx_t lco [32];
  logic [63:0]   lm  [32];
  logic [63:0]   lp  [32];
  logic          lv  [33];
  logic          lvo [32];
  logic          lb  [32];

  always_comb begin
    lc[0]      = c13o;
    lc[0].qres = p13;
    lc[0].frac = '0;
    lc[0].n    = cvq_pkg::ln_shift(c13o.ratio);
  end
  assign lm[0] = c13o.ratio >> lc[0].n;
  assign lv[0] = v13;

  for (genvar i = 0; i < 32; i++) begin : g_ln
    cvq_mul u_sq (.clk, .rst_n, .en(adv), .in_valid(lv[i]), .in_a(lm[i]), .in_b(lm[i]),
                  .in_ctx(lc[i]), .out_valid(lvo[i]), .out_p(lp[i]), .out_ctx(lco[i]));
    // square at or above two: halve and emit a one bit
    assign lb[i]   = |lp[i][63:33];
    assign lc[i+1] = cvq_pkg::push_frac(lco[i], lb[i]);
    assign lv[i+1] = lvo[i];
    if (i < 31) begin : g_next
      assign lm[i+1] = lb[i] ? lp[i] >> 1 : lp[i];
    end
  end

  // ---- links 15 to 17: log2 * ln2, times m, over (1-p)
  cvq_pkg::ctx_t c15o, c16o, c17o;
  logic [63:0]   p15, l15, p16, q17;
  logic          v15, v16, v17;

  cvq_mul u_m15 (.clk, .rst_n, .en(adv), .in_valid(lv[32]),
                 .in_a({27'd0, lc[32].n, lc[32].frac}), .in_b(cvq_pkg::LN2_Q32),
                 .in_ctx(lc[32]), .out_valid(v15), .out_p(p15), .out_ctx(c15o));

  // ratio below one means log taken as zero
  assign l15 = (c15o.ratio >= ONE) ? p15 : '0;

  cvq_mul u_m16 (.clk, .rst_n, .en(adv), .in_valid(v15), .in_a(l15), .in_b(c15o.m),
                 .in_ctx(c15o), .out_valid(v16), .out_p(p16), .out_ctx(c16o));
  cvq_rec #(.SQRT(1'b0)) u_d17 (.clk, .rst_n, .en(adv), .in_valid(v16), .in_a(p16),
    .in_b(ONE - c16o.p), .in_ctx(c16o), .out_valid(v17), .out_q(q17), .out_ctx(c17o));

  // ---- branch select and narrowing
  logic [63:0] res, rsh;
  logic [31:0] nv;
  logic [1:0]  br;

  always_comb begin
    priority if (c17o.psi <= pcw) begin
      br  = cvq_pkg::BR_QUAD;
      res = (c17o.psi == '0) ? c17o.m : c17o.qres;
    end else if (64'(c17o.u) <= c17o.p) begin
      br  = cvq_pkg::BR_ZERO;
      res = '0;
    end else begin
      br  = cvq_pkg::BR_TAIL;
      res = q17;
    end
    rsh = res >> SH;
    nv  = (|rsh[63:32]) ? '1 : rsh[31:0];
  end

  // ---- output register plus skid stage
  logic        out_valid_r;
  logic [31:0] out_nv_r, skid_nv_r;
  logic [1:0]  out_br_r, skid_br_r;
  logic        out_busy;

  assign out_busy = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (out_busy) begin
        if (adv && v17) begin
          skid_valid_r <= 1'b1;
        end
      end else if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= v17;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (out_busy) begin
      if (adv) begin
        skid_nv_r <= nv;
        skid_br_r <= br;
      end
    end else if (skid_valid_r) begin
      out_nv_r <= skid_nv_r;
      out_br_r <= skid_br_r;
    end else begin
      out_nv_r <= nv;
      out_br_r <= br;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_nv_r;
  assign out_tuser  = out_br_r;

endmodule
`default_nettype wire

// ----- hw/rtl/cvq_mul.sv -----
// two-stage saturating Q32.32 multiplier, (a*b)>>32, with context sideband
// depends on cvq_pkg
`default_nettype none
module cvq_mul (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [63:0]   in_a,
  input  wire logic [63:0]   in_b,
  input  wire cvq_pkg::ctx_t in_ctx,
  output logic               out_valid,
  output logic [63:0]        out_p,
  output cvq_pkg::ctx_t      out_ctx
);

  logic          v1_r, v2_r;
  logic [63:0]   ll_r, lh_r, hl_r, hh_r;
  logic [63:0]   p_r;
  cvq_pkg::ctx_t c1_r, c2_r;
  logic [33:0]   mid;
  logic [65:0]   up;
  logic [63:0]   p_nxt;

  always_comb begin
    mid = 34'(ll_r[63:32]) + 34'(lh_r[31:0]) + 34'(hl_r[31:0]);
    up  = 66'(hh_r) + 66'(lh_r[63:32]) + 66'(hl_r[63:32]) + 66'(mid[33:32]);
    if ((|hh_r[63:32]) || (|up[65:32])) begin
      p_nxt = '1;
    end else begin
      p_nxt = {up[31:0], mid[31:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= 64'(in_a[31:0])  * 64'(in_b[31:0]);
      lh_r <= 64'(in_a[31:0])  * 64'(in_b[63:32]);
      hl_r <= 64'(in_a[63:32]) * 64'(in_b[31:0]);
      hh_r <= 64'(in_a[63:32]) * 64'(in_b[63:32]);
      c1_r <= in_ctx;
      p_r  <= p_nxt;
      c2_r <= c1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_p     = p_r;
  assign out_ctx   = c2_r;

endmodule
`default_nettype wire

// ----- hw/rtl/cvq_rec.sv -----
// pipelined digit recurrence, one bit per stage: (a<<32)/b saturating,
// or floor(sqrt(a<<32)) when SQRT is set; depends on cvq_pkg
`default_nettype none
module cvq_rec #(
  parameter bit SQRT = 1'b0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [63:0]   in_a,
  input  wire logic [63:0]   in_b,
  input  wire cvq_pkg::ctx_t in_ctx,
  output logic               out_valid,
  output logic [63:0]        out_q,
  output cvq_pkg::ctx_t      out_ctx
);

  localparam int STEPS = SQRT ? 48 : 96;

  logic [STEPS-1:0] vld_r;
  logic [STEPS-1:0] sat_r;
  logic [STEPS-1:0] sat_nxt;
  logic [63:0]      r_r   [STEPS];
  logic [63:0]      q_r   [STEPS];
  logic [63:0]      sh_r  [STEPS];
  logic [63:0]      b_r   [STEPS];
  logic [63:0]      r_nxt [STEPS];
  logic [63:0]      q_nxt [STEPS];
  logic [63:0]      sh_nxt[STEPS];
  cvq_pkg::ctx_t    c_r   [STEPS];

  always_comb begin
    logic [63:0] rp, qp, shp, bp, rs, trial;
    logic        sp, take;
    for (int k = 0; k < STEPS; k++) begin
      if (k == 0) begin
        rp = '0; qp = '0; shp = in_a; bp = in_b; sp = 1'b0;
      end else begin
        rp = r_r[k-1]; qp = q_r[k-1]; shp = sh_r[k-1]; bp = b_r[k-1]; sp = sat_r[k-1];
      end
      if (SQRT) begin
        rs        = {rp[61:0], shp[63:62]};
        trial     = {qp[61:0], 2'b01};
        take      = rs >= trial;
        sh_nxt[k] = {shp[61:0], 2'b00};
        sat_nxt[k] = 1'b0;
      end else begin
        rs        = {rp[62:0], shp[63]};
        trial     = bp;
        take      = rp[63] || (rs >= bp);
        sh_nxt[k] = {shp[62:0], 1'b0};
        sat_nxt[k] = sp | qp[63];
      end
      r_nxt[k] = take ? rs - trial : rs;
      q_nxt[k] = {qp[62:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r <= sat_nxt;
      for (int k = 0; k < STEPS; k++) begin
        r_r[k]  <= r_nxt[k];
        q_r[k]  <= q_nxt[k];
        sh_r[k] <= sh_nxt[k];
        if (k == 0) begin
          b_r[k] <= in_b;
          c_r[k] <= in_ctx;
        end else begin
          b_r[k] <= b_r[k-1];
          c_r[k] <= c_r[k-1];
        end
      end
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_ctx   = c_r[STEPS-1];
  assign out_q     = (!SQRT && (sat_r[STEPS-1] || (b_r[STEPS-1] == '0))) ? '1 : q_r[STEPS-1];

endmodule
`default_nettype wire

// ----- hw/rtl/cvq_checker.sv -----
// port-level checks for the qe variance step, bound to the top level
// depends on cvq_pkg and cir_variance_qe_step
`default_nettype none
module cvq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // point mass branch always gives zero
  a_zero_branch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == cvq_pkg::BR_ZERO) |-> out_tdata == '0)
    else $error("point mass beat with nonzero variance");

  // only the three branch codes appear
  a_branch_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == cvq_pkg::BR_QUAD) || (out_tuser == cvq_pkg::BR_ZERO) ||
                   (out_tuser == cvq_pkg::BR_TAIL))
    else $error("bad branch code");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  // input side may only stall while the result side is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && $past(out_tvalid && !out_tready))
    else $error("input stalled without a blocked result");

endmodule

bind cir_variance_qe_step cvq_checker u_cvq_checker (.*);
`default_nettype wire

// ----- tb/tb_cir_variance_qe_step.sv -----
// self-checking testbench for the qe variance step: stream beats in, compare every result beat
// against an in-bench fixed point predictor; depends on cvq_pkg and cir_variance_qe_step
`default_nettype none
module tb_cir_variance_qe_step;
  import cvq_pkg::*;

  localparam int unsigned FB = 24;
  localparam logic [63:0] ALL1 = '1;
  localparam int unsigned LATENCY = 659;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [31:0] nvar;
    logic [1:0]  branch;
  } qe_result_t;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [87:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  cir_variance_qe_step #(.FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the registers
  logic [31:0] p_mean, p_decay, p_vol, p_speed, p_psi;

  qe_result_t pending_q[$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned snd_idle, rcv_idle;

  // ---------------------------------------------------------------- arithmetic
  function automatic logic [63:0] add_s(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ALL1 : s[63:0];
  endfunction

  // (a*b) >> 32 saturating
  function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return (p[127:96] != 0) ? ALL1 : p[95:32];
  endfunction

  // floor((a << 32) / b) saturating, divide by zero saturates
  function automatic logic [63:0] div_q(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] q;
    if (b == 0) return ALL1;
    q = {32'b0, a, 32'b0} / {64'b0, b};
    return (q[127:64] != 0) ? ALL1 : q[63:0];
  endfunction

  // floor(sqrt(x * 2^32)), bit by bit on the 96 bit radicand
  function automatic logic [63:0] sqrt_q(input logic [63:0] x);
    logic [127:0] rad, rem, root, trial;
    rad = {32'b0, x, 32'b0};
    rem = 0;
    root = 0;
    for (int i = 47; i >= 0; i--) begin
      rem = (rem << 2) | ((rad >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  // natural log of x >= 1.0 via log2 by repeated squaring
  function automatic logic [63:0] ln_q(input logic [63:0] x);
    logic [63:0] n, m, frac;
    n = 0;
    frac = 0;
    while (n < 31 && (x >> (33 + n)) != 0) n++;
    m = x >> n;
    for (int i = 0; i < 32; i++) begin
      m = mul_q(m, m);
      frac = frac << 1;
      if (m >= (ONE_Q << 1)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return mul_q((n << 32) | frac, LN2_Q32);
  endfunction

  function automatic qe_result_t qe_predict(input logic [31:0] var_in, input logic [23:0] z,
                                            input logic [31:0] u);
    logic [63:0] v, th, sg, kp, pc, e, ome, m, sg2, t1, t2, s2, m2, psi, res;
    logic [63:0] inv, q, b2, a, sb, zm, w, p, ratio, l;
    logic neg;
    qe_result_t r;
    v = {32'b0, var_in} << (32 - FB);
    th = {32'b0, p_mean} << (32 - FB);
    sg = {32'b0, p_vol} << (32 - FB);
    kp = {32'b0, p_speed} << (32 - FB);
    pc = {32'b0, p_psi} << (32 - FB);
    e = {32'b0, p_decay};
    ome = ONE_Q - e;
    m = (v >= th) ? add_s(th, mul_q(v - th, e)) : th - mul_q(th - v, e);
    sg2 = mul_q(sg, sg);
    t1 = div_q(mul_q(mul_q(mul_q(v, sg2), e), ome), kp);
    t2 = div_q(mul_q(mul_q(mul_q(th, sg2), ome), ome), kp) >> 1;
    s2 = add_s(t1, t2);
    m2 = mul_q(m, m);
    psi = (m2 == 0) ? ALL1 : div_q(s2, m2);
    if (psi <= pc) begin
      r.branch = BR_QUAD;
      if (psi == 0) begin
        res = m;
      end else begin
        inv = div_q(2 * ONE_Q, psi);
        q = (inv > ONE_Q) ? inv - ONE_Q : 0;
        b2 = add_s(q, mul_q(sqrt_q(inv), sqrt_q(q)));
        a = div_q(m, add_s(ONE_Q, b2));
        sb = sqrt_q(b2);
        neg = z[23];
        zm = (neg ? (64'h100_0000 - {40'b0, z}) : {40'b0, z}) << 12;
        if (!neg) w = add_s(sb, zm);
        else w = (sb >= zm) ? sb - zm : zm - sb;
        res = mul_q(a, mul_q(w, w));
      end
    end else begin
      p = 0;
      if (psi > ONE_Q) p = div_q(psi - ONE_Q, add_s(psi, ONE_Q));
      if (p >= ONE_Q) p = ONE_Q - 1;
      if ({32'b0, u} <= p) begin
        r.branch = BR_ZERO;
        res = 0;
      end else begin
        ratio = div_q(ONE_Q - p, ONE_Q - {32'b0, u});
        l = (ratio >= ONE_Q) ? ln_q(ratio) : 0;
        r.branch = BR_TAIL;
        res = div_q(mul_q(l, m), ONE_Q - p);
      end
    end
    res = res >> (32 - FB);
    r.nvar = (res[63:32] != 0) ? 32'hFFFF_FFFF : res[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- clock, reset, timeout
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cir_variance_qe_step: mismatch");
      $finish;
    end
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle);
  end

  // result checker: every result beat against the oldest expectation
  always @(posedge clk) begin
    qe_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result beat: nvar=%h branch=%0d", out_tdata, out_tuser);
        mismatches++;
      end else begin
        exp_r = pending_q.pop_front();
        if (exp_r.nvar !== out_tdata || exp_r.branch !== out_tuser) begin
          if (mismatches < 10)
            $display("result mismatch: expected nvar=%h branch=%0d, got nvar=%h branch=%0d",
                     exp_r.nvar, exp_r.branch, out_tdata, out_tuser);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- beat drivers
  task automatic send_item(input logic [31:0] v, input logic [23:0] z, input logic [31:0] u);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {u, z, v};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(qe_predict(v, z, u));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // registers only change once the pipeline is empty
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MEAN:  p_mean = val;
      REG_DECAY: p_decay = val;
      REG_VOL:   p_vol = val;
      REG_SPEED: p_speed = val;
      REG_PSI:   p_psi = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [31:0] mean, input logic [31:0] decay,
                               input logic [31:0] vol, input logic [31:0] speed,
                               input logic [31:0] thr);
    wait_drained();
    write_reg(REG_MEAN, mean);
    write_reg(REG_DECAY, decay);
    write_reg(REG_VOL, vol);
    write_reg(REG_SPEED, speed);
    write_reg(REG_PSI, thr);
  endtask

  function automatic logic [31:0] pick_wide(input int unsigned scale);
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(scale);
    endcase
  endfunction

  // random variance, mostly near the long term level so both branches show up
  function automatic logic [31:0] pick_variance();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(32'h0400_0000);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_field_extremes();
    // defaults after reset: field corners, both signs of z and u at both ends
    send_item(32'h0, 24'h0, 32'h0);
    send_item(32'hFFFF_FFFF, 24'h7F_FFFF, 32'hFFFF_FFFF);
    send_item(32'h000A_3D71, 24'h80_0000, 32'h0);
    send_item(32'h000A_3D71, 24'h7F_FFFF, 32'h8000_0000);
    send_item(32'h0100_0000, 24'hF0_0000, 32'hFFFF_FFFF);
    send_item(32'h0000_0001, 24'hFF_FFFF, 32'h0000_0001);
  endtask

  task automatic test_special_cases();
    // zero mean: no long term level and zero variance
    load_settings(32'h0, PSI_RST ^ 32'h0, VOL_RST, SPEED_RST, PSI_RST);
    send_item(32'h0, 24'h0, 32'h1234_5678);
    // zero vol of vol: conditional variance zero, quadratic returns the mean
    load_settings(MEAN_RST, DECAY_RST, 32'h0, SPEED_RST, PSI_RST);
    send_item(32'h0200_0000, 24'h10_0000, 32'h0);
    // huge vol, slow reversion: exponential branch, point mass and tail, full scale u
    load_settings(MEAN_RST, DECAY_RST, 32'hFFFF_FFFF, 32'h1, PSI_RST);
    send_item(32'h0001_0000, 24'h0, 32'h0);
    send_item(32'h0001_0000, 24'h0, 32'hFFFF_FFFF);
    send_item(32'h0100_0000, 24'h0, 32'hFFFF_FFF0);
    // zero reversion speed saturates the quotient
    load_settings(MEAN_RST, DECAY_RST, VOL_RST, 32'h0, PSI_RST);
    send_item(32'h0100_0000, 24'h0, 32'h8000_0000);
    // threshold above two and at the top: quadratic clamp, negative sum
    load_settings(MEAN_RST, DECAY_RST, 32'h0200_0000, SPEED_RST, 32'hFFFF_FFFF);
    send_item(32'h0010_0000, 24'h80_0000, 32'h0);
    send_item(32'h0010_0000, 24'hE0_0000, 32'h0);
    send_item(32'hFFFF_FFFF, 24'h7F_FFFF, 32'h0);
    // threshold below one and zero: psi below one gives p of zero
    load_settings(MEAN_RST, DECAY_RST, VOL_RST, SPEED_RST, 32'h0080_0000);
    send_item(32'h000A_3D71, 24'h0, 32'h0);
    send_item(32'h000A_3D71, 24'h0, 32'h0000_0001);
    load_settings(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_item(32'h0, 24'h0, 32'h4000_0000);
    send_item(32'hFFFF_FFFF, 24'h80_0000, 32'hFFFF_FFFF);
    load_settings(32'h0, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0);
    send_item(32'h0000_0001, 24'h00_0001, 32'h0);
  endtask

  task automatic test_random_phase(input int unsigned n_items);
    int unsigned k;
    for (k = 0; k < n_items; k++) begin
      if (k % 60 == 0)
        load_settings(pick_wide(32'h0200_0000), pick_wide(32'hFFFF_FFFF),
                      pick_wide(32'h0400_0000), pick_wide(32'h0800_0000) | 32'h1,
                      pick_wide(32'h0400_0000));
      send_item(pick_variance(), 24'($urandom), $urandom);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    mismatches = 0;
    snd_idle = 23;
    rcv_idle = 83;
    p_mean = MEAN_RST;
    p_decay = DECAY_RST;
    p_vol = VOL_RST;
    p_speed = SPEED_RST;
    p_psi = PSI_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_special_cases();
    test_random_phase(580);
    snd_idle = 83;
    rcv_idle = 23;
    test_random_phase(580);
    snd_idle = 0;
    rcv_idle = 0;
    test_random_phase(590);

    wait_drained();
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("cir_variance_qe_step: match");
    end else begin
      $display("cir_variance_qe_step: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
